// ===== rtl/aepr_pkg.sv =====
// Shared types, constants and controller/datapath command structs for the
// moving-average to PWM period block. No dependencies.
package aepr_pkg;

   localparam int SAMPLE_BITS = 12;

   localparam int WEIGHT_W = 8;
   localparam int AVG_W    = 12;
   localparam int LEVEL_W  = 12;
   localparam int FREQ_W   = 17;
   localparam int PERIOD_W = 14;
   localparam int HIGH_W   = 13;
   localparam int RANGE_W  = 4;

   // moving-average accumulator: new-sample and old-average products
   localparam int NEW_PROD_W = WEIGHT_W + SAMPLE_BITS;
   localparam int OLD_PROD_W = WEIGHT_W + 1 + AVG_W;
   localparam int SUM_W      = ((NEW_PROD_W > OLD_PROD_W) ? NEW_PROD_W : OLD_PROD_W) + 1;
   localparam int SHIFT_W    = SUM_W - WEIGHT_W;

   // frequency term level*range*9900/4085, reduced by 5 to level*range*1980/817
   localparam int SPAN_W       = 14;
   localparam int PROD1_W      = LEVEL_W + RANGE_W;
   localparam int SPAN_RED_W   = 11;
   localparam int SCALED_W     = PROD1_W + SPAN_RED_W;
   localparam int BASE_W       = 7;
   localparam int BASEP_W      = BASE_W + RANGE_W;

   // floor(x/817) as (x * ceil(2^37/817)) >> 37, exact for any x below 2^27
   localparam int RECIP_W      = 28;
   localparam int RECIP_SHIFT  = 37;
   localparam int RECIP_PROD_W = SCALED_W + RECIP_W;

   // restoring divider for the period
   localparam int QUO_W      = 18;
   localparam int REM_W      = FREQ_W;
   localparam int DIV2_STEPS = 14;
   localparam int CNT_W      = 5;

   localparam logic [WEIGHT_W-1:0]   WEIGHT_RESET = 8'd77;
   localparam logic [AVG_W-1:0]      AVG_MIN      = 12'd5;
   localparam logic [AVG_W-1:0]      AVG_MAX      = 12'd4090;
   localparam logic [REM_W-1:0]      LEVEL_SPAN   = 17'd4085;
   localparam logic [SPAN_W-1:0]     SPAN_HZ      = 14'd9900;
   localparam logic [SPAN_RED_W-1:0] SPAN_RED     = 11'd1980;
   localparam logic [RECIP_W-1:0]    RECIP_SPAN   = 28'd168223934;
   localparam logic [BASE_W-1:0]     BASE_HZ      = 7'd100;
   localparam logic [19:0]           US_PER_S     = 20'd1000000;
   localparam logic [RANGE_W-1:0]    RANGE_TOP    = 4'd10;
   localparam logic [RANGE_W-1:0]    RANGE_FIRST  = 4'd1;

   localparam logic [REM_W-1:0] DIV2_REM_INIT = REM_W'(US_PER_S >> DIV2_STEPS);
   localparam logic [QUO_W-1:0] DIV2_QUO_INIT =
      QUO_W'(US_PER_S[DIV2_STEPS-1:0]) << (QUO_W - DIV2_STEPS);

   localparam logic [CNT_W-1:0] DIV2_LAST = CNT_W'(DIV2_STEPS - 1);

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   click;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]  level;
      logic [FREQ_W-1:0]   freq_hz;
      logic [PERIOD_W-1:0] pwm_period;
      logic [HIGH_W-1:0]   high_us;
      logic [RANGE_W-1:0]  range_index;
   } rsp_type;

   typedef struct packed {
      logic accept;    // capture request, advance range on click
      logic ema;       // update moving average and level
      logic check;     // decide emission, track last level
      logic mul1;      // level * range
      logic mul2;      // * 1980
      logic recip;     // reciprocal multiply for / 817
      logic div_step;  // one restoring divider step
      logic freq;      // form frequency, load divider for 1e6 / freq
      logic out_load;  // write result register
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/aepr_ctrl.sv =====
// Sequencing state machine for the moving-average to PWM period block.
// Depends on aepr_pkg; drives cmd_type to the datapath, reads status_type.
module aepr_ctrl import aepr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_EMA   = 4'd1;
   localparam logic [3:0] ST_CHK   = 4'd2;
   localparam logic [3:0] ST_MUL1  = 4'd3;
   localparam logic [3:0] ST_MUL2  = 4'd4;
   localparam logic [3:0] ST_RECIP = 4'd5;
   localparam logic [3:0] ST_FREQ  = 4'd6;
   localparam logic [3:0] ST_DIV2  = 4'd7;
   localparam logic [3:0] ST_OUT   = 4'd8;

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EMA;
            end
         end
         ST_EMA: begin
            cmd.ema  = 1'b1;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            cmd.check = 1'b1;
            state_in  = status.emit ? ST_MUL1 : ST_IDLE;
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_RECIP;
         end
         ST_RECIP: begin
            cmd.recip = 1'b1;
            state_in  = ST_FREQ;
         end
         ST_FREQ: begin
            cmd.freq = 1'b1;
            cnt_in   = DIV2_LAST;
            state_in = ST_DIV2;
         end
         ST_DIV2: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the result register can take the new request's result
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== rtl/aepr_dp.sv =====
// Datapath: moving average, range index, frequency and period arithmetic,
// period divider and result register. Depends on aepr_pkg.
module aepr_dp import aepr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  req_type             req_data,
   input  logic                csr_write,
   input  logic [WEIGHT_W-1:0] csr_data,
   input  cmd_type             cmd,
   output status_type          status,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data
);

   // configuration and persistent state
   logic [WEIGHT_W-1:0]    weight_ff;
   logic [AVG_W-1:0]       average_ff, average_in;
   logic [LEVEL_W-1:0]     last_level_ff;
   logic [RANGE_W-1:0]     range_ff;
   logic                   pending_ff;
   logic                   emitted_ff;

   // per-request working registers
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic [LEVEL_W-1:0]     level_ff;
   logic [PROD1_W-1:0]     prod1_ff;
   logic [SCALED_W-1:0]    scaled_ff;
   logic [FREQ_W-1:0]      freq_ff, freq_in;
   logic [REM_W-1:0]       rem_ff, divisor_ff;
   logic [QUO_W-1:0]       quo_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff;

   // moving average
   logic [NEW_PROD_W-1:0]  prod_new;
   logic [WEIGHT_W:0]      weight_old;
   logic [OLD_PROD_W-1:0]  prod_old;
   logic [SUM_W-1:0]       sum;
   logic [SHIFT_W-1:0]     acc;

   // frequency
   logic [RECIP_PROD_W-1:0] recip_prod;
   logic [BASEP_W-1:0]     base_hz;

   // divider step
   logic [REM_W+1:0]       trial;
   logic                   quo_bit;

   assign prod_new   = weight_ff * sample_ff;
   assign weight_old = (WEIGHT_W+1)'(1 << WEIGHT_W) - {1'b0, weight_ff};
   assign prod_old   = weight_old * average_ff;
   assign sum        = SUM_W'(prod_new) + SUM_W'(prod_old);
   assign acc        = sum[SUM_W-1:WEIGHT_W];

   always_comb begin
      if (acc < SHIFT_W'(AVG_MIN)) begin
         average_in = AVG_MIN;
      end else if (acc > SHIFT_W'(AVG_MAX)) begin
         average_in = AVG_MAX;
      end else begin
         average_in = AVG_W'(acc);
      end
   end

   assign recip_prod = scaled_ff * RECIP_SPAN;
   assign base_hz    = BASE_HZ * range_ff;
   assign freq_in    = FREQ_W'(base_hz) + quo_ff[FREQ_W-1:0];

   assign trial   = {1'b0, rem_ff, quo_ff[QUO_W-1]} - {2'b00, divisor_ff};
   assign quo_bit = ~trial[REM_W+1];

   assign status.emit     = !emitted_ff || (level_ff != last_level_ff) || pending_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control and persistent state
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff     <= WEIGHT_RESET;
         average_ff    <= '0;
         last_level_ff <= '0;
         range_ff      <= RANGE_FIRST;
         pending_ff    <= 1'b0;
         emitted_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            weight_ff <= csr_data;
         end
         if (cmd.accept && req_data.click) begin
            range_ff   <= (range_ff >= RANGE_TOP) ? RANGE_FIRST : range_ff + 1'b1;
            pending_ff <= 1'b1;
         end
         if (cmd.ema) begin
            average_ff <= average_in;
         end
         if (cmd.check) begin
            last_level_ff <= level_ff;
            if (status.emit) begin
               emitted_ff <= 1'b1;
               pending_ff <= 1'b0;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= req_data.sample;
      end
      if (cmd.ema) begin
         level_ff <= average_in - AVG_MIN;
      end
      if (cmd.mul1) begin
         prod1_ff <= level_ff * range_ff;
      end
      if (cmd.mul2) begin
         scaled_ff <= prod1_ff * SPAN_RED;
      end
      if (cmd.recip) begin
         quo_ff <= recip_prod[RECIP_SHIFT +: QUO_W];
      end
      if (cmd.freq) begin
         freq_ff    <= freq_in;
         rem_ff     <= DIV2_REM_INIT;
         quo_ff     <= DIV2_QUO_INIT;
         divisor_ff <= freq_in;
      end
      if (cmd.div_step) begin
         rem_ff <= quo_bit ? trial[REM_W-1:0] : {rem_ff[REM_W-2:0], quo_ff[QUO_W-1]};
         quo_ff <= {quo_ff[QUO_W-2:0], quo_bit};
      end
      if (cmd.out_load) begin
         rsp_ff.level       <= level_ff;
         rsp_ff.freq_hz     <= freq_ff;
         rsp_ff.pwm_period  <= quo_ff[PERIOD_W-1:0];
         rsp_ff.high_us     <= quo_ff[PERIOD_W-1:1];
         rsp_ff.range_index <= range_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/adc_ema_to_pwm_period_ranged.sv =====
// Top level of the moving-average to PWM period block.
// Depends on aepr_pkg, aepr_ctrl and aepr_dp.
//
// Request channel (req_valid/req_stall/req_data): one converter sample and a
//   click flag per request; a click advances the range index 1..10 with wrap
//   before the sample is folded into the moving average.
// Result channel (rsp_valid/rsp_stall/rsp_data): level, frequency, period,
//   high time and range index; a result appears on the first request, on a
//   level change and on a range change, otherwise none.
// Register port (csr_valid/csr_ready/csr_data): moving-average weight in
//   1/256 units; csr_ready is always high. Write it only while idle.
// Timing: one request at a time. A request with a result keeps req_stall high
//   through average, check, two multiplies, a reciprocal multiply for the
//   divide by 817, frequency, a 14-step divide of 1e6 by the frequency and
//   result load, which waits while a stalled result holds the output
//   register; the result is valid the cycle after the load. A request with
//   no result passes only average and check. The divider yields one bit per cycle.
// Reset (synchronous, active high): weight 77, average and last level zero,
//   range 1, no result pending. A stalled result stays in the output register
//   while the next request is taken; only a second finished result waits.
module adc_ema_to_pwm_period_ranged import aepr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [WEIGHT_W-1:0] csr_data
);

   cmd_type    cmd;
   status_type status;

   // accept a weight write on any cycle
   assign csr_ready = 1'b1;

   aepr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   aepr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== bench/adc_ema_to_pwm_period_ranged_tb.sv =====
// Self-checking bench for adc_ema_to_pwm_period_ranged: a scoreboard class
// predicts each PWM period result from the accepted requests and checks it.
// Depends on aepr_pkg and the adc_ema_to_pwm_period_ranged RTL.
module adc_ema_to_pwm_period_ranged_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import aepr_pkg::*;

   // Longest legal quiet stretch is the receiver hold below plus one request's
   // processing; the limit leaves a wide margin over that.
   localparam int QUIET_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;
   // Let a trailing request with no result finish too.
   localparam int SETTLE_CYCLES = 60;
   localparam int MAX_REPORTS = 40;

   // Tracks the moving average, range and emission state of the block and
   // keeps the PWM period results still owed by it, oldest first.
   class period_scoreboard;
      logic [WEIGHT_W-1:0] weight = WEIGHT_RESET;
      logic [AVG_W-1:0]    average = '0;
      logic [LEVEL_W-1:0]  last_level = '0;
      logic [RANGE_W-1:0]  range_now = RANGE_FIRST;
      bit                  range_pending = 1'b0;
      bit                  emitted_before = 1'b0;
      rsp_type             owed_periods[$];
      int                  errors = 0;

      function void set_weight(logic [WEIGHT_W-1:0] w);
         weight = w;
      endfunction

      function int pending();
         return owed_periods.size();
      endfunction

      // Advance the model by one accepted request and queue any result.
      function void note_request(req_type r);
         int unsigned avg_next;
         int unsigned lvl;
         int unsigned rng;
         longint unsigned freq;
         longint unsigned period;
         rsp_type want;
         if (r.click) begin
            range_now = (range_now >= RANGE_TOP) ? RANGE_FIRST : range_now + 1'b1;
            range_pending = 1'b1;
         end
         avg_next = (int'(weight) * int'(r.sample)
                     + (256 - int'(weight)) * int'(average)) >> 8;
         if (avg_next < AVG_MIN) avg_next = AVG_MIN;
         if (avg_next > AVG_MAX) avg_next = AVG_MAX;
         average = avg_next[AVG_W-1:0];
         lvl = avg_next - AVG_MIN;
         rng = range_now;
         freq = longint'(BASE_HZ) * rng
              + (longint'(lvl) * longint'(SPAN_HZ) * rng) / longint'(LEVEL_SPAN);
         period = longint'(US_PER_S) / freq;
         if (emitted_before && lvl == last_level && !range_pending) begin
            last_level = lvl[LEVEL_W-1:0];
            return;
         end
         last_level = lvl[LEVEL_W-1:0];
         emitted_before = 1'b1;
         range_pending = 1'b0;
         want.level = lvl[LEVEL_W-1:0];
         want.freq_hz = freq[FREQ_W-1:0];
         want.pwm_period = period[PERIOD_W-1:0];
         want.high_us = period[HIGH_W:1];
         want.range_index = range_now;
         owed_periods.push_back(want);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: %s mismatch, expected %0d, actual %0d",
                        $time, name, want, got);
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (owed_periods.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: unexpected result, expected none, actual level %0d freq %0d",
                        $time, got.level, got.freq_hz);
            return;
         end
         want = owed_periods.pop_front();
         compare_field("level", want.level, got.level);
         compare_field("freq_hz", want.freq_hz, got.freq_hz);
         compare_field("pwm_period", want.pwm_period, got.pwm_period);
         compare_field("high_us", want.high_us, got.high_us);
         compare_field("range_index", want.range_index, got.range_index);
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [WEIGHT_W-1:0] csr_data = '0;

   period_scoreboard board = new();

   int send_idle_pct = 0;   // chance per cycle that the sender holds off
   int stall_pct = 0;       // chance per cycle that the receiver stalls
   int quiet_cycles = 0;    // cycles since anything was accepted
   bit hold_go = 1'b0;      // toggle to start a long receiver hold
   bit hold_seen = 1'b0;
   int hold_left = 0;

   adc_ema_to_pwm_period_ranged dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Note every accepted request in the scoreboard and track quiet cycles.
   // Signals are sampled at the edge, before any update made there lands.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         board.note_request(req_data);
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
                     || (csr_valid && csr_ready)))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   // Receiver: check accepted results, then pick the stall for the next cycle.
   // A toggle of hold_go starts a long hold counted here, so the block fills
   // up and stalls its request side while the sender keeps offering.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_data);
      if (hold_go != hold_seen) begin
         hold_seen <= hold_go;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Watchdog: end the run if nothing moves for too long.
   initial begin
      do @(posedge clock); while (quiet_cycles < QUIET_LIMIT);
      $display("Verification failed");
      $finish;
   end

   // Offer one request, idling first at random, and hold it until accepted.
   // Valid stays high into the next request when no idle cycle is drawn.
   task automatic send_request(logic [SAMPLE_BITS-1:0] sample, logic click);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data.sample <= sample;
      req_data.click <= click;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Wait for every owed result, then let a trailing request with no
   // result drain out of the datapath.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_weight(logic [WEIGHT_W-1:0] w);
      csr_valid <= 1'b1;
      csr_data <= w;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      board.set_weight(w);
   endtask

   task automatic start_phase(logic [WEIGHT_W-1:0] w, int idle, int stall);
      wait_idle();
      write_weight(w);
      send_idle_pct = idle;
      stall_pct = stall;
   endtask

   // Mostly runs of one held sample so the average settles and some requests
   // yield no result; the rest are single fully random requests.
   task automatic run_samples(int count);
      logic [SAMPLE_BITS-1:0] held;
      int run_len;
      int sent;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) == 0) begin
            send_request(SAMPLE_BITS'($urandom_range(0, 4095)),
                         1'($urandom_range(0, 1)));
            sent++;
         end else begin
            case ($urandom_range(0, 9))
               0: held = '0;
               1: held = '1;
               default: held = SAMPLE_BITS'($urandom_range(0, 4095));
            endcase
            run_len = $urandom_range(1, 12);
            repeat (run_len) begin
               send_request(held, $urandom_range(0, 99) < 8);
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset weight: first request always emits, a repeat stays silent,
      // and a click with an unchanged level still emits.
      send_request(12'd0, 1'b0);
      send_request(12'd0, 1'b0);
      send_request(12'd0, 1'b1);

      // Full weight: drive the average to the top clamp, hold it there,
      // then click through range 10 and wrap back to 1.
      start_phase(8'd255, 0, 0);
      repeat (4) send_request(12'hFFF, 1'b0);
      repeat (10) send_request(12'hFFF, 1'b1);
      // Drop to the bottom clamp, then hold.
      repeat (3) send_request(12'd0, 1'b0);

      // Zero weight: average stays put, only the range click emits.
      start_phase(8'd0, 0, 0);
      send_request(12'hFFF, 1'b1);
      send_request(12'd0, 1'b0);

      // Random phases over weights and idling patterns.
      start_phase(8'd1, 0, 0);
      run_samples(200);
      start_phase(8'd255, 49, 0);
      run_samples(200);
      start_phase(WEIGHT_W'($urandom_range(2, 254)), 0, 49);
      run_samples(200);
      start_phase(WEIGHT_W'($urandom_range(2, 254)), 14, 14);
      run_samples(200);

      // Back pressure: hold off the receiver while requests keep coming.
      start_phase(8'd128, 0, 0);
      run_samples(30);
      hold_go <= ~hold_go;
      run_samples(170);

      wait_idle();
      if (board.errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/aepr_pkg.sv
rtl/aepr_ctrl.sv
rtl/aepr_dp.sv
rtl/adc_ema_to_pwm_period_ranged.sv
bench/adc_ema_to_pwm_period_ranged_tb.sv
